[design/pcfa_pkg.sv]
// ----------------------------------------------------------------------------
// pcfa_pkg: shared types and constants of the per-CPU page allocator
// Page and list geometry, result and action codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package pcfa_pkg;

  // Geometry. PAGE_COUNT and CPU_COUNT are powers of two: the link slot is
  // the low bits of the page number and the list index the low bits of the
  // CPU number.
  localparam int CPU_COUNT  = 8;
  localparam int PAGE_COUNT = 32768;
  localparam int CPU_W      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int SLOT_W     = $clog2(PAGE_COUNT);
  localparam int PNUM_W     = 20;
  localparam int LINK_W     = PNUM_W + 1;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_W     = 32;
  localparam int CPU_ID_W   = 3;
  localparam int STATUS_W   = 2;

  // Configuration register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [ADDR_W-1:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] REGION_STOP_RST  = 32'h8800_0000;

  typedef enum logic {
    REG_REGION_START = 1'b0,
    REG_REGION_STOP  = 1'b1
  } reg_idx_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOCATED = 2'd0,
    ST_FREED     = 2'd1,
    ST_NO_MEM    = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WB
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;      // capture the accepted transfer
    logic commit_free;  // check address, push page, load result
    logic rd_link;      // pick a list and read the link below its head
    logic pop;          // move the head down and load result
    logic no_mem;       // load an out-of-memory result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free;      // captured item is a free
    logic any_list;     // some list holds a page
  } dp_status_t;

endpackage

[design/pcfa_regs.sv]
// ----------------------------------------------------------------------------
// pcfa_regs: region bound registers
// APB-style slave holding region_start and region_stop. Zero wait states.
// ----------------------------------------------------------------------------
module pcfa_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pcfa_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pcfa_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pcfa_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [pcfa_pkg::ADDR_W-1:0]      region_start,
  output logic [pcfa_pkg::ADDR_W-1:0]      region_stop
);

  logic [pcfa_pkg::ADDR_W-1:0] start_r;
  logic [pcfa_pkg::ADDR_W-1:0] stop_r;
  logic                        wr_en;
  pcfa_pkg::reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  // registers sit on a 4-byte stride
  assign idx    = pcfa_pkg::reg_idx_t'(paddr[2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= pcfa_pkg::REGION_START_RST;
      stop_r  <= pcfa_pkg::REGION_STOP_RST;
    end else if (wr_en) begin
      unique case (idx)
        pcfa_pkg::REG_REGION_START: start_r <= pwdata;
        pcfa_pkg::REG_REGION_STOP:  stop_r  <= pwdata;
        default:                    start_r <= start_r;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      pcfa_pkg::REG_REGION_START: prdata = start_r;
      pcfa_pkg::REG_REGION_STOP:  prdata = stop_r;
      default:                    prdata = '0;
    endcase
  end

  assign region_start = start_r;
  assign region_stop  = stop_r;

endmodule

[design/pcfa_ctrl.sv]
// ----------------------------------------------------------------------------
// pcfa_ctrl: allocator sequencer
// Accepts one transfer, steps it through the datapath and owns the result
// valid flag of the output register.
// ----------------------------------------------------------------------------
module pcfa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  pcfa_pkg::dp_status_t  dp_status,
  output pcfa_pkg::dp_cmd_t     dp_cmd
);

  pcfa_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             result_load;

  // output slot can take a result this cycle
  assign out_free    = !out_valid_r || !out_stall;
  assign result_load = dp_cmd.commit_free | dp_cmd.pop | dp_cmd.no_mem;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcfa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      pcfa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.load_in = 1'b1;
          state_nxt      = pcfa_pkg::S_EXEC;
        end
      end
      pcfa_pkg::S_EXEC: begin
        priority if (dp_status.is_free) begin
          if (out_free) begin
            dp_cmd.commit_free = 1'b1;
            state_nxt          = pcfa_pkg::S_IDLE;
          end
        end else if (!dp_status.any_list) begin
          if (out_free) begin
            dp_cmd.no_mem = 1'b1;
            state_nxt     = pcfa_pkg::S_IDLE;
          end
        end else begin
          // link read does not touch the output slot
          dp_cmd.rd_link = 1'b1;
          state_nxt      = pcfa_pkg::S_WB;
        end
      end
      pcfa_pkg::S_WB: begin
        if (out_free) begin
          dp_cmd.pop = 1'b1;
          state_nxt  = pcfa_pkg::S_IDLE;
        end
      end
      default: state_nxt = pcfa_pkg::S_IDLE;
    endcase
  end

  // result valid: set on load, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (result_load)               out_valid_nxt = 1'b1;
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    result_load |-> out_free)
    else $error("result loaded over a pending transfer");

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({dp_cmd.load_in, dp_cmd.commit_free, dp_cmd.rd_link,
              dp_cmd.pop, dp_cmd.no_mem}))
    else $error("conflicting datapath commands");

  // a link read is always followed by the write-back step
  a_rd_then_wb: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.rd_link |=> state_r == pcfa_pkg::S_WB)
    else $error("link read not followed by write-back");

  // every accepted transfer goes to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == pcfa_pkg::S_EXEC)
    else $error("accepted transfer not executed");
`endif

endmodule

[design/pcfa_datapath.sv]
// ----------------------------------------------------------------------------
// pcfa_datapath: list heads, next-link store and result register
// Holds the per-CPU list heads, the link memory indexed by page number,
// the free address check, the steal priority encoder and the output fields.
// ----------------------------------------------------------------------------
module pcfa_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pcfa_pkg::dp_cmd_t                  dp_cmd,
  output pcfa_pkg::dp_status_t               dp_status,
  input  logic                               in_action,
  input  logic [pcfa_pkg::CPU_ID_W-1:0]      in_cpu_id,
  input  logic [pcfa_pkg::ADDR_W-1:0]        in_page_address,
  input  logic [pcfa_pkg::ADDR_W-1:0]        region_start,
  input  logic [pcfa_pkg::ADDR_W-1:0]        region_stop,
  output logic [pcfa_pkg::STATUS_W-1:0]      out_status,
  output logic [pcfa_pkg::ADDR_W-1:0]        out_granted_address,
  output logic [pcfa_pkg::CPU_ID_W-1:0]      out_source_cpu
);

  localparam int CPU_COUNT = pcfa_pkg::CPU_COUNT;
  localparam int CPU_W     = pcfa_pkg::CPU_W;

  // captured transfer
  logic                          action_r;
  logic [CPU_W-1:0]              cpu_r;
  logic [pcfa_pkg::ADDR_W-1:0]   addr_r;

  // list heads
  logic                          head_valid_r [CPU_COUNT];
  logic [pcfa_pkg::PNUM_W-1:0]   head_pnum_r  [CPU_COUNT];

  // link store
  logic [pcfa_pkg::LINK_W-1:0]   link_mem [pcfa_pkg::PAGE_COUNT];
  logic [pcfa_pkg::LINK_W-1:0]   link_rdata_r;
  logic [CPU_W-1:0]              list_r;

  logic [CPU_W-1:0]              sel_list;
  logic                          any_valid;
  logic                          addr_ok;
  logic [pcfa_pkg::PNUM_W-1:0]   free_pnum;
  logic [pcfa_pkg::SLOT_W-1:0]   free_slot;
  logic [pcfa_pkg::SLOT_W-1:0]   rd_slot;
  logic                          push;

  pcfa_pkg::status_t             status_r;
  logic [pcfa_pkg::ADDR_W-1:0]   grant_r;
  logic [pcfa_pkg::CPU_ID_W-1:0] src_r;

  // capture transfer; CPU number folds onto the list count
  always_ff @(posedge clk) begin
    if (dp_cmd.load_in) begin
      action_r <= in_action;
      cpu_r    <= CPU_W'(in_cpu_id);
      addr_r   <= in_page_address;
    end
  end

  // free address check
  assign addr_ok   = (addr_r[pcfa_pkg::PAGE_SHIFT-1:0] == '0) &&
                     (addr_r >= region_start) && (addr_r < region_stop);
  assign free_pnum = addr_r[pcfa_pkg::PAGE_SHIFT +: pcfa_pkg::PNUM_W];
  assign free_slot = free_pnum[pcfa_pkg::SLOT_W-1:0];
  assign push      = dp_cmd.commit_free && addr_ok;

  // own list first, else lowest-numbered other non-empty list
  always_comb begin
    sel_list  = cpu_r;
    any_valid = 1'b0;
    for (int i = CPU_COUNT - 1; i >= 0; i--) begin
      if (head_valid_r[i]) any_valid = 1'b1;
      if (!head_valid_r[cpu_r] && head_valid_r[i] && (CPU_W'(i) != cpu_r)) begin
        sel_list = CPU_W'(i);
      end
    end
  end

  assign rd_slot = head_pnum_r[sel_list][pcfa_pkg::SLOT_W-1:0];

  assign dp_status.is_free  = (pcfa_pkg::action_t'(action_r) == pcfa_pkg::ACT_FREE);
  assign dp_status.any_list = any_valid;

  // link store write (push) and registered read (pop)
  always_ff @(posedge clk) begin
    if (push) begin
      link_mem[free_slot] <= {head_valid_r[cpu_r], head_pnum_r[cpu_r]};
    end
    if (dp_cmd.rd_link) begin
      link_rdata_r <= link_mem[rd_slot];
      list_r       <= sel_list;
    end
  end

  // head valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CPU_COUNT; i++) head_valid_r[i] <= 1'b0;
    end else if (push) begin
      head_valid_r[cpu_r] <= 1'b1;
    end else if (dp_cmd.pop) begin
      head_valid_r[list_r] <= link_rdata_r[pcfa_pkg::PNUM_W];
    end
  end

  // head page numbers
  always_ff @(posedge clk) begin
    if (push) begin
      head_pnum_r[cpu_r] <= free_pnum;
    end else if (dp_cmd.pop) begin
      head_pnum_r[list_r] <= link_rdata_r[pcfa_pkg::PNUM_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    priority if (dp_cmd.commit_free) begin
      status_r <= addr_ok ? pcfa_pkg::ST_FREED : pcfa_pkg::ST_BAD_FREE;
      grant_r  <= '0;
      src_r    <= '0;
    end else if (dp_cmd.no_mem) begin
      status_r <= pcfa_pkg::ST_NO_MEM;
      grant_r  <= '0;
      src_r    <= '0;
    end else if (dp_cmd.pop) begin
      status_r <= pcfa_pkg::ST_ALLOCATED;
      grant_r  <= {head_pnum_r[list_r], {pcfa_pkg::PAGE_SHIFT{1'b0}}};
      src_r    <= pcfa_pkg::CPU_ID_W'(list_r);
    end else begin
      status_r <= status_r;
    end
  end

  assign out_status          = status_r;
  assign out_granted_address = grant_r;
  assign out_source_cpu      = src_r;

endmodule

[design/per_cpu_page_free_list_allocator_unit.sv]
// Steps: a free is accepted, then checked and its result loaded; an
// allocate adds the registered read of the next-link memory first.
// The controller holds one item at a time and its result until the output
// slot is free; it takes the next item while a result waits.
// Reset: synchronous, active low; all lists empty, region bounds at their
// defaults. The link memory is not cleared.
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator_unit: per-CPU free-list page allocator
// One LIFO free list of 4 KiB pages per CPU; alloc pops the own list or
// steals from the lowest non-empty other list, free pushes checked pages.
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [pcfa_pkg::CPU_ID_W-1:0]     in_cpu_id,
  input  logic [pcfa_pkg::ADDR_W-1:0]       in_page_address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pcfa_pkg::STATUS_W-1:0]     out_status,
  output logic [pcfa_pkg::ADDR_W-1:0]       out_granted_address,
  output logic [pcfa_pkg::CPU_ID_W-1:0]     out_source_cpu,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pcfa_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [pcfa_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [pcfa_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  pcfa_pkg::dp_cmd_t           dp_cmd;
  pcfa_pkg::dp_status_t        dp_status;
  logic [pcfa_pkg::ADDR_W-1:0] region_start;
  logic [pcfa_pkg::ADDR_W-1:0] region_stop;

  // configuration registers
  pcfa_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .region_start (region_start),
    .region_stop  (region_stop)
  );

  // sequencer
  pcfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  // lists, link store and result fields
  pcfa_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .dp_cmd              (dp_cmd),
    .dp_status           (dp_status),
    .in_action           (in_action),
    .in_cpu_id           (in_cpu_id),
    .in_page_address     (in_page_address),
    .region_start        (region_start),
    .region_stop         (region_stop),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_source_cpu      (out_source_cpu)
  );

endmodule
